// ===== design/sodf_pkg.sv =====
// ----------------------------------------------------------------------------
// sodf_pkg
// Types and constants shared by the odometry frame deframer.
// ----------------------------------------------------------------------------
package sodf_pkg;

    localparam int unsigned FRAME_LEN = 31;
    localparam int unsigned WIN_DEPTH = 30;
    localparam int unsigned CNT_W     = 5;

    localparam logic [7:0] HDR0     = 8'h55;
    localparam logic [7:0] HDR1     = 8'hAA;
    localparam logic [7:0] DATA_LEN = 8'h1B;

    localparam logic [CNT_W-1:0] MIN_HDR   = 5'd2;
    localparam logic [CNT_W-1:0] MIN_LEN   = 5'd3;
    localparam logic [CNT_W-1:0] FULL_CNT  = 5'd31;
    localparam logic [CNT_W-1:0] SUM_FIRST = 5'd2;
    localparam logic [CNT_W-1:0] SUM_LAST  = 5'd29;

    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic fill_clr;
        logic sum_clr;
        logic sum_add;
        cnt_t sum_idx;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        cnt_t fill;
        logic hdr_ok;
        logic len_ok;
        logic sum_ok;
        logic out_full;
    } dp_stat_t;

endpackage

// ===== design/sodf_if.sv =====
// ----------------------------------------------------------------------------
// sodf_byte_if / sodf_odo_if
// Valid/ready channels: received bytes in, decoded odometry reports out.
// ----------------------------------------------------------------------------
interface sodf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sodf_odo_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x_cm;
    logic signed [31:0] pos_y_cm;
    logic signed [31:0] heading_centideg;
    logic signed [15:0] vel_x_cm_s;
    logic signed [15:0] vel_y_cm_s;
    logic signed [15:0] turn_rate_mrad_s;
    logic [7:0]         motor_fault_a;
    logic [7:0]         motor_fault_b;
    logic [7:0]         motor_fault_c;
    logic [7:0]         motor_fault_d;
    logic [7:0]         drive_status;

    modport source (output valid, output pos_x_cm, output pos_y_cm,
                    output heading_centideg, output vel_x_cm_s, output vel_y_cm_s,
                    output turn_rate_mrad_s, output motor_fault_a, output motor_fault_b,
                    output motor_fault_c, output motor_fault_d, output drive_status,
                    input ready);
    modport sink   (input valid, input pos_x_cm, input pos_y_cm,
                    input heading_centideg, input vel_x_cm_s, input vel_y_cm_s,
                    input turn_rate_mrad_s, input motor_fault_a, input motor_fault_b,
                    input motor_fault_c, input motor_fault_d, input drive_status,
                    output ready);
endinterface

// ===== design/sodf_dp.sv =====
// ----------------------------------------------------------------------------
// sodf_dp
// Byte window shift line, fill count, checksum accumulator, result register.
// ----------------------------------------------------------------------------
module sodf_dp
    import sodf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x_cm,
    output logic signed [31:0] pos_y_cm,
    output logic signed [31:0] heading_centideg,
    output logic signed [15:0] vel_x_cm_s,
    output logic signed [15:0] vel_y_cm_s,
    output logic signed [15:0] turn_rate_mrad_s,
    output logic [7:0]         motor_fault_a,
    output logic [7:0]         motor_fault_b,
    output logic [7:0]         motor_fault_c,
    output logic [7:0]         motor_fault_d,
    output logic [7:0]         drive_status
);

    logic [7:0] buf_reg [FRAME_LEN];
    cnt_t       fill_reg;
    logic [7:0] acc_reg;
    logic       out_valid_reg;

    // window shift line; oldest byte at index 0
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            buf_reg[fill_reg] <= rx_byte;
        end
        else if (cmd.shift)
        begin
            for (int i = 0; i < FRAME_LEN - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cmd.fill_clr)
        begin
            fill_reg <= '0;
        end
        else if (cmd.load)
        begin
            fill_reg <= fill_reg + cnt_t'(1);
        end
        else if (cmd.shift)
        begin
            fill_reg <= fill_reg - cnt_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_clr)
        begin
            acc_reg <= '0;
        end
        else if (cmd.sum_add)
        begin
            acc_reg <= acc_reg + buf_reg[cmd.sum_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pos_x_cm         <= {buf_reg[6], buf_reg[5], buf_reg[4], buf_reg[3]};
            pos_y_cm         <= {buf_reg[10], buf_reg[9], buf_reg[8], buf_reg[7]};
            heading_centideg <= {buf_reg[14], buf_reg[13], buf_reg[12], buf_reg[11]};
            vel_x_cm_s       <= {buf_reg[16], buf_reg[15]};
            vel_y_cm_s       <= {buf_reg[18], buf_reg[17]};
            turn_rate_mrad_s <= {buf_reg[20], buf_reg[19]};
            motor_fault_a    <= buf_reg[25];
            motor_fault_b    <= buf_reg[26];
            motor_fault_c    <= buf_reg[27];
            motor_fault_d    <= buf_reg[28];
            drive_status     <= buf_reg[29];
        end
    end

    assign out_valid     = out_valid_reg;
    assign stat.fill     = fill_reg;
    assign stat.hdr_ok   = (buf_reg[0] == HDR0) && (buf_reg[1] == HDR1);
    assign stat.len_ok   = (buf_reg[2] == DATA_LEN);
    assign stat.sum_ok   = (acc_reg == buf_reg[FRAME_LEN-1]);
    assign stat.out_full = out_valid_reg;

endmodule

// ===== design/sodf_ctrl.sv =====
// ----------------------------------------------------------------------------
// sodf_ctrl
// Sequencer: byte intake, header/length scan, checksum walk, frame commit.
// ----------------------------------------------------------------------------
module sodf_ctrl
    import sodf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     rx_valid,
    output logic     rx_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SUM,
        ST_CHECK
    } state_t;

    state_t state_reg, state_next;
    cnt_t   idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= SUM_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.sum_idx  = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (rx_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.fill < MIN_HDR)
                begin
                    state_next = ST_IDLE;
                end
                else if (!stat.hdr_ok)
                begin
                    cmd.shift = 1'b1;
                end
                else if (stat.fill < MIN_LEN)
                begin
                    state_next = ST_IDLE;
                end
                else if (!stat.len_ok)
                begin
                    cmd.shift = 1'b1;
                end
                else if (stat.fill != FULL_CNT)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.sum_clr = 1'b1;
                    idx_next    = SUM_FIRST;
                    state_next  = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum_add = 1'b1;
                idx_next    = idx_reg + cnt_t'(1);
                if (idx_reg == SUM_LAST)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!stat.sum_ok)
                begin
                    cmd.shift  = 1'b1;
                    state_next = ST_SCAN;
                end
                else if (!stat.out_full)
                begin
                    cmd.out_load = 1'b1;
                    cmd.fill_clr = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rx_ready = (state_reg == ST_IDLE);

endmodule

// ===== design/serial_odometry_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// serial_odometry_frame_deframer_unit
// Finds 31-byte odometry frames in a received byte stream and decodes them.
// ----------------------------------------------------------------------------
// Channels: rx takes one received byte per beat; res gives one decoded report
// per good frame (55 AA, length 27, 27 data bytes, 8-bit sum of length+data).
// Both are valid/ready; a beat moves when valid and ready are high together.
// Each byte goes through intake and then a scan, and a bad header or length
// drops the oldest byte and scans again. When 31 bytes line up, a checksum walk
// over the length and data bytes and a compare follow; a bad sum drops the
// oldest byte and rescans the window. The rescan and checksum walk run over
// the window shift line, one step per cycle, and rx is not ready until they
// finish. A report is loaded into the output register once the checksum
// matches and that register is empty. Reset empties the window and clears
// res.valid. A stalled receiver holds the report in the output register while
// bytes keep flowing; only a second frame completing before the first is taken waits for it.
// ----------------------------------------------------------------------------
module serial_odometry_frame_deframer_unit
    import sodf_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    sodf_byte_if.sink    rx,
    sodf_odo_if.source   res
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sodf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_ready (rx.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sodf_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .rx_byte          (rx.rx_byte),
        .out_valid        (res.valid),
        .out_ready        (res.ready),
        .pos_x_cm         (res.pos_x_cm),
        .pos_y_cm         (res.pos_y_cm),
        .heading_centideg (res.heading_centideg),
        .vel_x_cm_s       (res.vel_x_cm_s),
        .vel_y_cm_s       (res.vel_y_cm_s),
        .turn_rate_mrad_s (res.turn_rate_mrad_s),
        .motor_fault_a    (res.motor_fault_a),
        .motor_fault_b    (res.motor_fault_b),
        .motor_fault_c    (res.motor_fault_c),
        .motor_fault_d    (res.motor_fault_d),
        .drive_status     (res.drive_status)
    );

endmodule

// ===== design/sodf_checker.sv =====
// ----------------------------------------------------------------------------
// sodf_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module sodf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rx_valid,
    input logic        rx_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [31:0] res_pos_x_cm,
    input logic [7:0]  res_drive_status
);

    // stalled report holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_pos_x_cm)
            && $stable(res_drive_status))
        else $error("report changed while stalled");

    // every byte is scanned before the next is taken
    a_rx_gap: assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && rx_ready |=> !rx_ready)
        else $error("byte taken back to back");

    // a report is committed on return to intake
    a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> rx_ready)
        else $error("report raised while scanning");

    // a new report rises only when rx was not ready just before it
    a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> !$past(rx_ready))
        else $error("report without scan");

endmodule

bind serial_odometry_frame_deframer_unit sodf_checker u_sodf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rx_valid         (rx.valid),
    .rx_ready         (rx.ready),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .res_pos_x_cm     (res.pos_x_cm),
    .res_drive_status (res.drive_status)
);

// ===== sim/sodf_frame_checker.sv =====
// ----------------------------------------------------------------------------
// sodf_frame_checker
// Watches the byte and report channels of the odometry frame deframer.
// Every accepted byte goes through a model of the frame search, which keeps
// the queue of reports the block owes. Every accepted report is compared
// field by field with the oldest of them.
// ----------------------------------------------------------------------------
module sodf_frame_checker
    import sodf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    sodf_byte_if  rx,
    sodf_odo_if   res,
    output int    fail_count,
    output int    frames_found,
    output int    reports_checked,
    output int    reports_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] pos_x_cm;
        logic signed [31:0] pos_y_cm;
        logic signed [31:0] heading_centideg;
        logic signed [15:0] vel_x_cm_s;
        logic signed [15:0] vel_y_cm_s;
        logic signed [15:0] turn_rate_mrad_s;
        logic [7:0]         motor_fault_a;
        logic [7:0]         motor_fault_b;
        logic [7:0]         motor_fault_c;
        logic [7:0]         motor_fault_d;
        logic [7:0]         drive_status;
    } odo_report_t;

    odo_report_t owed_reports [$];
    logic [7:0]  held_bytes [WIN_DEPTH];
    int unsigned held_count;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report_error($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    // One received byte: append to the held bytes and search for a frame.
    task automatic take_byte(input logic [7:0] b);
        logic [7:0]  scan [FRAME_LEN];
        int unsigned n;
        logic [7:0]  sum;
        bit          settled;
        bit          reject;
        odo_report_t rep;
        n = held_count;
        for (int k = 0; k < n; k++)
        begin
            scan[k] = held_bytes[k];
        end
        scan[n] = b;
        n++;
        settled = 1'b0;
        while (n >= 2 && !settled)
        begin
            reject = 1'b0;
            if (scan[0] != HDR0 || scan[1] != HDR1)
            begin
                reject = 1'b1;
            end
            else if (n < 3)
            begin
                settled = 1'b1;
            end
            else if (scan[2] != DATA_LEN)
            begin
                reject = 1'b1;
            end
            else if (n < FRAME_LEN)
            begin
                settled = 1'b1;
            end
            else
            begin
                sum = 8'h00;
                for (int k = 2; k < FRAME_LEN - 1; k++)
                begin
                    sum = sum + scan[k];
                end
                if (sum != scan[FRAME_LEN-1])
                begin
                    reject = 1'b1;
                end
                else
                begin
                    rep.pos_x_cm         = {scan[6], scan[5], scan[4], scan[3]};
                    rep.pos_y_cm         = {scan[10], scan[9], scan[8], scan[7]};
                    rep.heading_centideg = {scan[14], scan[13], scan[12], scan[11]};
                    rep.vel_x_cm_s       = {scan[16], scan[15]};
                    rep.vel_y_cm_s       = {scan[18], scan[17]};
                    rep.turn_rate_mrad_s = {scan[20], scan[19]};
                    rep.motor_fault_a    = scan[25];
                    rep.motor_fault_b    = scan[26];
                    rep.motor_fault_c    = scan[27];
                    rep.motor_fault_d    = scan[28];
                    rep.drive_status     = scan[29];
                    owed_reports.push_back(rep);
                    frames_found++;
                    n = 0;
                    settled = 1'b1;
                end
            end
            if (reject)
            begin
                for (int k = 0; k < n - 1; k++)
                begin
                    scan[k] = scan[k+1];
                end
                n--;
            end
        end
        for (int k = 0; k < n; k++)
        begin
            held_bytes[k] = scan[k];
        end
        held_count = n;
    endtask

    task automatic check_report();
        odo_report_t want;
        if (owed_reports.size() == 0)
        begin
            report_error("report beat with no frame owed");
        end
        else
        begin
            want = owed_reports.pop_front();
            check_field("pos_x_cm", res.pos_x_cm, want.pos_x_cm);
            check_field("pos_y_cm", res.pos_y_cm, want.pos_y_cm);
            check_field("heading_centideg", res.heading_centideg, want.heading_centideg);
            check_field("vel_x_cm_s", 32'(res.vel_x_cm_s), 32'(want.vel_x_cm_s));
            check_field("vel_y_cm_s", 32'(res.vel_y_cm_s), 32'(want.vel_y_cm_s));
            check_field("turn_rate_mrad_s", 32'(res.turn_rate_mrad_s),
                        32'(want.turn_rate_mrad_s));
            check_field("motor_fault_a", 32'(res.motor_fault_a), 32'(want.motor_fault_a));
            check_field("motor_fault_b", 32'(res.motor_fault_b), 32'(want.motor_fault_b));
            check_field("motor_fault_c", 32'(res.motor_fault_c), 32'(want.motor_fault_c));
            check_field("motor_fault_d", 32'(res.motor_fault_d), 32'(want.motor_fault_d));
            check_field("drive_status", 32'(res.drive_status), 32'(want.drive_status));
            reports_checked++;
        end
    endtask

    initial
    begin
        fail_count      = 0;
        frames_found    = 0;
        reports_checked = 0;
        reports_owed    = 0;
        held_count      = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx.valid === 1'b1 && rx.ready === 1'b1)
            begin
                take_byte(rx.rx_byte);
            end
            if (res.valid === 1'b1 && res.ready === 1'b1)
            begin
                check_report();
            end
            reports_owed = owed_reports.size();
        end
    end

endmodule

// ===== sim/tb_serial_odometry_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_serial_odometry_frame_deframer_unit
// Byte stream stimulus for the odometry frame deframer.
// A directed run of good frames at the field extremes and of broken headers,
// lengths, sums and cut-off frames, then a random mix of frames and noise
// bytes, with random idling on both channels and one long hold-off of the
// report channel. Checking is done by sodf_frame_checker.
// ----------------------------------------------------------------------------
module tb_serial_odometry_frame_deframer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sodf_pkg::*;

    typedef enum {FLAW_NONE, FLAW_SUM, FLAW_LEN, FLAW_HDR, FLAW_CUT} frame_flaw_t;

    localparam int DATA_BYTES    = 27;
    localparam int BYTE_TARGET   = 1500;
    localparam int FRAME_TARGET  = 40;
    localparam int HOLD_CYCLES   = 800;
    localparam int DRAIN_CYCLES  = 200;
    localparam int CYCLE_LIMIT   = 1000000;

    logic clk;
    logic rst_n;

    sodf_byte_if rx_ch ();
    sodf_odo_if  res_ch ();

    int fail_count;
    int frames_found;
    int reports_checked;
    int reports_owed;

    int cycle_count;
    int bytes_sent;
    int holds_requested;
    int holds_served;
    bit steady;

    logic [7:0] payload [DATA_BYTES];

    serial_odometry_frame_deframer_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch)
    );

    sodf_frame_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx              (rx_ch),
        .res             (res_ch),
        .fail_count      (fail_count),
        .frames_found    (frames_found),
        .reports_checked (reports_checked),
        .reports_owed    (reports_owed)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports owed", cycle_count, reports_owed);
            $display("simulation failed");
            $finish;
        end
    end

    // Report channel: random stalls, plus one long hold-off on request.
    initial
    begin
        res_ch.ready <= 1'b0;
        holds_served = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_requested)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                holds_served++;
            end
            else if (!steady && $urandom_range(99) < 20)
            begin
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < 20)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (rx_ch.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    // Fill everything with one value, sign bytes of the signed fields with another.
    task automatic set_payload(input logic [7:0] fill, input logic [7:0] msb);
        for (int k = 0; k < DATA_BYTES; k++)
        begin
            payload[k] = fill;
        end
        payload[3]  = msb;
        payload[7]  = msb;
        payload[11] = msb;
        payload[13] = msb;
        payload[15] = msb;
        payload[17] = msb;
    endtask

    function automatic logic [7:0] random_byte();
        case ($urandom_range(9))
            0: random_byte = HDR0;
            1: random_byte = HDR1;
            2: random_byte = DATA_LEN;
            default: random_byte = 8'($urandom_range(255));
        endcase
    endfunction

    task automatic randomize_payload();
        for (int k = 0; k < DATA_BYTES; k++)
        begin
            payload[k] = ($urandom_range(7) == 0) ? random_byte() : 8'($urandom_range(255));
        end
    endtask

    task automatic emit_frame(input frame_flaw_t flaw);
        logic [7:0] sum;
        int         count;
        sum = DATA_LEN;
        for (int k = 0; k < DATA_BYTES; k++)
        begin
            sum = sum + payload[k];
        end
        count = (flaw == FLAW_CUT) ? $urandom_range(DATA_BYTES - 1) : DATA_BYTES;
        send_byte(HDR0);
        send_byte((flaw == FLAW_HDR) ? HDR0 : HDR1);
        send_byte((flaw == FLAW_LEN) ? (DATA_LEN ^ 8'(1 << $urandom_range(7))) : DATA_LEN);
        for (int k = 0; k < count; k++)
        begin
            send_byte(payload[k]);
        end
        if (flaw != FLAW_CUT)
        begin
            send_byte((flaw == FLAW_SUM) ? (sum ^ 8'($urandom_range(1, 255))) : sum);
        end
    endtask

    initial
    begin
        int pick;
        int count;
        rst_n           <= 1'b0;
        rx_ch.valid     <= 1'b0;
        rx_ch.rx_byte   <= 8'h00;
        cycle_count     = 0;
        bytes_sent      = 0;
        holds_requested = 0;
        steady          = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lone junk byte, field extremes, broken frames then resync
        send_byte(HDR1);
        set_payload(8'h00, 8'h00);
        emit_frame(FLAW_NONE);
        set_payload(8'h00, 8'h80);
        emit_frame(FLAW_NONE);
        set_payload(8'hFF, 8'h7F);
        emit_frame(FLAW_NONE);
        send_byte(HDR0);
        set_payload(8'hFF, 8'hFF);
        emit_frame(FLAW_NONE);
        randomize_payload();
        emit_frame(FLAW_LEN);
        emit_frame(FLAW_NONE);
        emit_frame(FLAW_SUM);
        randomize_payload();
        emit_frame(FLAW_NONE);
        emit_frame(FLAW_CUT);
        randomize_payload();
        emit_frame(FLAW_NONE);

        // output held off while frames keep coming, so the input backs up
        holds_requested <= holds_requested + 1;
        repeat (4)
        begin
            randomize_payload();
            emit_frame(FLAW_NONE);
        end

        while (bytes_sent < BYTE_TARGET || frames_found < FRAME_TARGET)
        begin
            steady <= (bytes_sent > 700 && bytes_sent < 1000);
            randomize_payload();
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                emit_frame(FLAW_NONE);
            end
            else if (pick < 68)
            begin
                emit_frame(FLAW_SUM);
            end
            else if (pick < 74)
            begin
                emit_frame(FLAW_LEN);
            end
            else if (pick < 79)
            begin
                emit_frame(FLAW_HDR);
            end
            else if (pick < 85)
            begin
                emit_frame(FLAW_CUT);
            end
            else
            begin
                count = $urandom_range(1, 6);
                repeat (count) send_byte(random_byte());
            end
        end
        rx_ch.valid <= 1'b0;
        steady      <= 1'b0;

        while (reports_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes with random gaps and stalls and one long output hold-off",
                 bytes_sent);
        $display("decoded %0d frames, %0d reports compared", frames_found, reports_checked);
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
